// ----- sv/utf8_sanitizer_assert.svh -----
// ----------------------------------------------------------------------------
// utf8_sanitizer assertion macros
// Short forms for the concurrent checks of the sanitizer.
// ----------------------------------------------------------------------------
`ifndef UTF8_SANITIZER_ASSERT_SVH
`define UTF8_SANITIZER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define UTF8S_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define UTF8S_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/utf8s_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8s_pkg
// Types, constants and byte classification shared by the sanitizer modules.
// ----------------------------------------------------------------------------
package utf8s_pkg;

   localparam int BYTE_W       = 8;
   localparam int CAP_W        = 13;
   localparam int MAX_CAPACITY = 4096;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_SEL_BIT  = 2;

   // register indexes
   localparam logic CSR_LINEFEED = 1'b0;
   localparam logic CSR_CAPACITY = 1'b1;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 13'd1024;

   localparam logic [7:0] MARKER     = 8'hBB;
   localparam logic [7:0] PAIR_LEAD  = 8'hC2;
   localparam logic [7:0] LINE_FEED  = 8'h0A;
   localparam logic [7:0] QMARK      = 8'h3F;
   localparam logic [7:0] TERMINATOR = 8'h00;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_VAL   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_VAL  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_VAL  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_VAL  = 8'hF0;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } group_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_APPEND,
      OP_HOLD,
      OP_SEQ,
      OP_QMARK,
      OP_SCAN_H1,
      OP_SCAN_H2,
      OP_SCAN_B
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load_item;
      logic   clear_held;
      logic   check_pass;
      logic   check_fail;
      logic   emit;
      logic   term;
   } cmd_type;

   typedef struct packed {
      logic       held_nz;
      logic [1:0] held_count;
      logic       b_cont;
      logic       b_zero;
      logic       b_lead;
      logic       seq_complete;
      logic       stopped;
      logic       fits;
      logic       emit_last;
      logic       slot_free;
   } sts_type;

   // full sequence length of a lead byte, zero when it is no multi-byte lead
   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      if ((b & LEAD2_MASK) == LEAD2_VAL) begin
         len = 3'd2;
      end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
         len = 3'd3;
      end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

   // output group for a byte at a lead position that is not held
   function automatic group_type scan_group(input logic [7:0] b, input logic lf_mode);
      group_type g;
      g = '0;
      if (b == MARKER) begin
         if (lf_mode) begin
            g.bytes[0] = LINE_FEED;
            g.len      = 3'd1;
         end else begin
            g.bytes[0] = PAIR_LEAD;
            g.bytes[1] = MARKER;
            g.len      = 3'd2;
         end
      end else if (b[7] == 1'b0) begin
         g.bytes[0] = b;
         g.len      = 3'd1;
      end else begin
         g.bytes[0] = QMARK;
         g.len      = 3'd1;
      end
      return g;
   endfunction

endpackage

// ----- sv/utf8s_req_if.sv -----
// ----------------------------------------------------------------------------
// utf8s_req_if
// Source byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface utf8s_req_if;
   logic                          valid;
   logic                          ready;
   logic [utf8s_pkg::BYTE_W-1:0]  data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- sv/utf8s_rsp_if.sv -----
// ----------------------------------------------------------------------------
// utf8s_rsp_if
// Sanitized byte channel: valid/ready handshake, output byte and last flag.
// ----------------------------------------------------------------------------
interface utf8s_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [utf8s_pkg::BYTE_W-1:0]  out_byte;
   logic                          is_last;

   modport source (output valid, output out_byte, output is_last, input ready);
   modport sink   (input valid, input out_byte, input is_last, output ready);
endinterface

// ----- sv/utf8s_ctrl.sv -----
// ----------------------------------------------------------------------------
// utf8s_ctrl
// Sequencer: walks each source byte through held-sequence handling, rescans,
// capacity checks and byte-wise emission by commanding the datapath.
// ----------------------------------------------------------------------------
module utf8s_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  utf8s_pkg::sts_type sts,
   output utf8s_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_RESCAN1,
      S_RESCAN2,
      S_MAIN,
      S_CHECK,
      S_EMIT,
      S_TERM
   } state_type;

   // where to continue once the current group is checked and emitted
   typedef enum logic [1:0] {
      AFT_DONE,
      AFT_RESCAN1,
      AFT_RESCAN2,
      AFT_MAIN
   } after_type;

   state_type state_ff, state_in, after_state;
   after_type after_ff, after_in;

   always_comb begin
      case (after_ff)
         AFT_RESCAN1: after_state = S_RESCAN1;
         AFT_RESCAN2: after_state = S_RESCAN2;
         AFT_MAIN:    after_state = S_MAIN;
         default:     after_state = S_IDLE;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      after_in  = after_ff;
      cmd       = '0;
      cmd.op    = utf8s_pkg::OP_NONE;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (sts.held_nz && sts.b_cont) begin
               if (sts.seq_complete) begin
                  cmd.op   = utf8s_pkg::OP_SEQ;
                  after_in = AFT_DONE;
                  state_in = S_CHECK;
               end else begin
                  cmd.op   = utf8s_pkg::OP_APPEND;
                  state_in = S_IDLE;
               end
            end else if (sts.held_nz) begin
               // broken sequence: replace the lead, then rescan what followed it
               cmd.op   = utf8s_pkg::OP_QMARK;
               after_in = AFT_RESCAN1;
               state_in = S_CHECK;
            end else begin
               state_in = S_MAIN;
            end
         end
         S_RESCAN1: begin
            if (sts.held_count >= 2'd2) begin
               cmd.op   = utf8s_pkg::OP_SCAN_H1;
               after_in = AFT_RESCAN2;
               state_in = S_CHECK;
            end else begin
               state_in = S_MAIN;
            end
         end
         S_RESCAN2: begin
            if (sts.held_count == 2'd3) begin
               cmd.op   = utf8s_pkg::OP_SCAN_H2;
               after_in = AFT_MAIN;
               state_in = S_CHECK;
            end else begin
               state_in = S_MAIN;
            end
         end
         S_MAIN: begin
            cmd.clear_held = 1'b1;
            if (sts.b_zero) begin
               state_in = S_TERM;
            end else if (sts.stopped) begin
               state_in = S_IDLE;
            end else if (sts.b_lead) begin
               cmd.op   = utf8s_pkg::OP_HOLD;
               state_in = S_IDLE;
            end else begin
               cmd.op   = utf8s_pkg::OP_SCAN_B;
               after_in = AFT_DONE;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.stopped) begin
               state_in = after_state;
            end else if (sts.fits) begin
               cmd.check_pass = 1'b1;
               state_in       = S_EMIT;
            end else begin
               cmd.check_fail = 1'b1;
               state_in       = after_state;
            end
         end
         S_EMIT: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) begin
                  state_in = after_state;
               end
            end
         end
         S_TERM: begin
            if (sts.slot_free) begin
               cmd.term = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         after_ff <= AFT_DONE;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
      end
   end

endmodule

// ----- sv/utf8s_dpath.sv -----
// ----------------------------------------------------------------------------
// utf8s_dpath
// Datapath: current byte, held sequence, output group buffer, byte counter,
// stop flag and the result output register.
// ----------------------------------------------------------------------------
module utf8s_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  utf8s_pkg::cmd_type            cmd,
   output utf8s_pkg::sts_type            sts,
   input  logic [utf8s_pkg::BYTE_W-1:0]  req_data,
   input  logic                          linefeed_mode,
   input  logic [utf8s_pkg::CAP_W-1:0]   out_capacity,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [utf8s_pkg::BYTE_W-1:0]  rsp_byte,
   output logic                          rsp_last
);

   logic [7:0]                  item_ff, item_in;
   logic [7:0]                  held_ff [0:2];
   logic [7:0]                  held_in [0:2];
   logic [1:0]                  held_cnt_ff, held_cnt_in;
   logic [2:0]                  exp_len_ff, exp_len_in;
   logic [utf8s_pkg::CAP_W-1:0] written_ff, written_in;
   logic                        stopped_ff, stopped_in;
   utf8s_pkg::group_type        grp_ff, grp_in;
   logic [1:0]                  idx_ff, idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_byte_ff, rsp_byte_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [utf8s_pkg::CAP_W-1:0] cap_eff;
   logic [utf8s_pkg::CAP_W:0]   need;
   logic                        slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // clamp the capacity; the group plus the terminator must fit
   assign cap_eff = (out_capacity > utf8s_pkg::CAP_W'(utf8s_pkg::MAX_CAPACITY))
                  ? utf8s_pkg::CAP_W'(utf8s_pkg::MAX_CAPACITY) : out_capacity;
   assign need    = {1'b0, written_ff} + (utf8s_pkg::CAP_W+1)'(grp_ff.len)
                  + (utf8s_pkg::CAP_W+1)'(1);

   always_comb begin
      sts              = '0;
      sts.held_nz      = (held_cnt_ff != 2'd0);
      sts.held_count   = held_cnt_ff;
      sts.b_cont       = ((item_ff & utf8s_pkg::CONT_MASK) == utf8s_pkg::CONT_VAL);
      sts.b_zero       = (item_ff == utf8s_pkg::TERMINATOR);
      sts.b_lead       = (utf8s_pkg::lead_len(item_ff) != 3'd0);
      sts.seq_complete = (({1'b0, held_cnt_ff} + 3'd1) >= exp_len_ff);
      sts.stopped      = stopped_ff;
      sts.fits         = (need <= {1'b0, cap_eff});
      sts.emit_last    = (({1'b0, idx_ff} + 3'd1) == grp_ff.len);
      sts.slot_free    = slot_free;
   end

   always_comb begin
      item_in      = item_ff;
      held_in      = held_ff;
      held_cnt_in  = held_cnt_ff;
      exp_len_in   = exp_len_ff;
      written_in   = written_ff;
      stopped_in   = stopped_ff;
      grp_in       = grp_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.load_item) begin
         item_in = req_data;
      end
      if (cmd.clear_held) begin
         held_cnt_in = 2'd0;
      end

      case (cmd.op)
         utf8s_pkg::OP_APPEND: begin
            case (held_cnt_ff)
               2'd1:    held_in[1] = item_ff;
               2'd2:    held_in[2] = item_ff;
               default: ;
            endcase
            held_cnt_in = held_cnt_ff + 2'd1;
         end
         utf8s_pkg::OP_HOLD: begin
            held_in[0]  = item_ff;
            held_cnt_in = 2'd1;
            exp_len_in  = utf8s_pkg::lead_len(item_ff);
         end
         utf8s_pkg::OP_SEQ: begin
            // held bytes first, then the closing continuation
            grp_in.bytes[0] = held_ff[0];
            grp_in.bytes[1] = (held_cnt_ff > 2'd1) ? held_ff[1] : item_ff;
            grp_in.bytes[2] = (held_cnt_ff > 2'd2) ? held_ff[2] : item_ff;
            grp_in.bytes[3] = item_ff;
            grp_in.len      = {1'b0, held_cnt_ff} + 3'd1;
            held_cnt_in     = 2'd0;
         end
         utf8s_pkg::OP_QMARK: begin
            grp_in          = '0;
            grp_in.bytes[0] = utf8s_pkg::QMARK;
            grp_in.len      = 3'd1;
         end
         utf8s_pkg::OP_SCAN_H1: grp_in = utf8s_pkg::scan_group(held_ff[1], linefeed_mode);
         utf8s_pkg::OP_SCAN_H2: grp_in = utf8s_pkg::scan_group(held_ff[2], linefeed_mode);
         utf8s_pkg::OP_SCAN_B:  grp_in = utf8s_pkg::scan_group(item_ff, linefeed_mode);
         default: ;
      endcase

      if (cmd.check_pass) begin
         written_in = written_ff + utf8s_pkg::CAP_W'(grp_ff.len);
         idx_in     = 2'd0;
      end
      if (cmd.check_fail) begin
         stopped_in = 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = grp_ff.bytes[idx_ff];
         rsp_last_in  = 1'b0;
         idx_in       = idx_ff + 2'd1;
      end
      if (cmd.term) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = utf8s_pkg::TERMINATOR;
         rsp_last_in  = 1'b1;
         held_cnt_in  = 2'd0;
         exp_len_in   = 3'd0;
         written_in   = '0;
         stopped_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff  <= 2'd0;
         exp_len_ff   <= 3'd0;
         written_ff   <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_cnt_ff  <= held_cnt_in;
         exp_len_ff   <= exp_len_in;
         written_ff   <= written_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      held_ff     <= held_in;
      grp_ff      <= grp_in;
      idx_ff      <= idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ----- sv/utf8_sanitizer.sv -----
// ----------------------------------------------------------------------------
// utf8_sanitizer
// Turns a zero-terminated byte stream into structurally valid UTF-8 under an output
// capacity limit, with a selectable expansion of the 0xBB line marker.
//
//   channel | direction | handshake                      | payload
//   req     | in        | valid/ready                    | data_byte
//   rsp     | out       | valid/ready                    | out_byte, is_last
//   csr     | in        | psel/penable/pwrite, pready=1  | linefeed_mode @0, out_capacity @4
//
// One byte is in work at a time. A stored continuation passes dispatch; a held
// lead dispatch and main; a scanned byte dispatch, main, check and emit; a
// continuation that completes a sequence dispatch, check and emit; the
// terminator dispatch, main and term. A broken sequence emits '?' for the lead,
// then rescans the bytes that followed it. A group dropped for capacity is not
// emitted. The sequencer holds while the full rsp output register is not taken.
// Synchronous reset returns to idle with registers at their reset values.
// ----------------------------------------------------------------------------
`include "utf8_sanitizer_assert.svh"

module utf8_sanitizer (
   input  logic                              clock,
   input  logic                              reset,
   utf8s_req_if.sink                         req,
   utf8s_rsp_if.source                       rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [utf8s_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [utf8s_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [utf8s_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);

   logic                        linefeed_ff, linefeed_in;
   logic [utf8s_pkg::CAP_W-1:0] capacity_ff, capacity_in;
   logic                        csr_write;
   logic                        csr_sel;
   utf8s_pkg::cmd_type          cmd;
   utf8s_pkg::sts_type          sts;
   logic                        out_write;
   logic                        dp_busy;
   logic                        str_clear;
   logic                        last_seen;
   logic                        last_zero;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = csr_paddr[utf8s_pkg::CSR_SEL_BIT];

   always_comb begin
      linefeed_in = linefeed_ff;
      capacity_in = capacity_ff;
      if (csr_write) begin
         case (csr_sel)
            utf8s_pkg::CSR_LINEFEED: linefeed_in = csr_pwdata[0];
            utf8s_pkg::CSR_CAPACITY: capacity_in = csr_pwdata[utf8s_pkg::CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         utf8s_pkg::CSR_LINEFEED:
            csr_prdata = utf8s_pkg::CSR_DATA_W'(linefeed_ff);
         default:
            csr_prdata = utf8s_pkg::CSR_DATA_W'(capacity_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         linefeed_ff <= 1'b0;
         capacity_ff <= utf8s_pkg::CAPACITY_RESET;
      end else begin
         linefeed_ff <= linefeed_in;
         capacity_ff <= capacity_in;
      end
   end

   utf8s_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   utf8s_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_data      (req.data_byte),
      .linefeed_mode (linefeed_ff),
      .out_capacity  (capacity_ff),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp.valid),
      .rsp_byte      (rsp.out_byte),
      .rsp_last      (rsp.is_last)
   );

   assign out_write = cmd.emit || cmd.term;
   assign dp_busy   = out_write || cmd.check_pass;
   assign str_clear = !sts.stopped && !sts.held_nz;
   assign last_seen = rsp.valid && rsp.is_last;
   assign last_zero = (rsp.out_byte == utf8s_pkg::TERMINATOR);

   `UTF8S_ASSERT_SAME(a_idle_quiet, clock, reset, req.ready, !dp_busy, "output while accepting")
   `UTF8S_ASSERT_SAME(a_emit_slot_free, clock, reset, out_write, sts.slot_free, "slot not free")
   `UTF8S_ASSERT_NEXT(a_term_clears, clock, reset, cmd.term, str_clear, "string state kept")
   `UTF8S_ASSERT_SAME(a_last_is_zero, clock, reset, last_seen, last_zero, "last on nonzero byte")

endmodule

// ----- dv/utf8_sanitizer_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_sanitizer_checker
// Watches the byte channels and the register port of the sanitizer, predicts
// the sanitized stream byte by byte and compares every result transaction
// in order against the prediction.
// ----------------------------------------------------------------------------
module utf8_sanitizer_checker (
   input  logic                              clock,
   input  logic                              reset,
   utf8s_req_if                              req,
   utf8s_rsp_if                              rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [utf8s_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [utf8s_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                              csr_pready,
   output int                                mismatch_count,
   output int                                pending_count
);

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } out_byte_type;

   out_byte_type     expected_out[$];

   // predictor state
   logic [7:0]       lead_buf [3];
   int unsigned      lead_fill;
   int unsigned      seq_total;
   int unsigned      out_written;
   logic             out_halted;
   logic             marker_lf;
   logic [utf8s_pkg::CAP_W-1:0] cap_limit;

   out_byte_type     want;

   task automatic report(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic push_out(input logic [7:0] value, input logic last);
      out_byte_type e;
      e.value = value;
      e.last  = last;
      expected_out.push_back(e);
   endtask

   // byte i of the group sits at bits 8*i+7:8*i
   task automatic write_group(input logic [31:0] group, input int unsigned k);
      int unsigned cap;
      int unsigned i;
      cap = (cap_limit > utf8s_pkg::MAX_CAPACITY) ? utf8s_pkg::MAX_CAPACITY : cap_limit;
      if (out_halted) return;
      // keep room for the terminator
      if (out_written + k + 1 > cap) begin
         out_halted = 1'b1;
         return;
      end
      for (i = 0; i < k; i++) push_out(group[8*i +: 8], 1'b0);
      out_written += k;
   endtask

   task automatic scan_lead(input logic [7:0] b);
      int unsigned len;
      if (b == utf8s_pkg::MARKER) begin
         if (marker_lf) write_group({24'h0, utf8s_pkg::LINE_FEED}, 1);
         else write_group({16'h0, utf8s_pkg::MARKER, utf8s_pkg::PAIR_LEAD}, 2);
         return;
      end
      if (b[7] == 1'b0) begin
         write_group({24'h0, b}, 1);
         return;
      end
      if ((b & utf8s_pkg::LEAD2_MASK) == utf8s_pkg::LEAD2_VAL) begin
         len = 2;
      end else if ((b & utf8s_pkg::LEAD3_MASK) == utf8s_pkg::LEAD3_VAL) begin
         len = 3;
      end else if ((b & utf8s_pkg::LEAD4_MASK) == utf8s_pkg::LEAD4_VAL) begin
         len = 4;
      end else begin
         write_group({24'h0, utf8s_pkg::QMARK}, 1);
         return;
      end
      if (out_halted) return;
      lead_buf[0] = b;
      lead_fill   = 1;
      seq_total   = len;
   endtask

   task automatic sanitize_byte(input logic [7:0] b);
      logic [31:0] seq;
      logic [7:0]  rescan [3];
      int unsigned n;
      int unsigned i;
      if (lead_fill > 0) begin
         if ((b & utf8s_pkg::CONT_MASK) == utf8s_pkg::CONT_VAL) begin
            if (lead_fill + 1 >= seq_total) begin
               seq = '0;
               for (i = 0; i < lead_fill; i++) seq[8*i +: 8] = lead_buf[i];
               seq[8*lead_fill +: 8] = b;
               n = lead_fill + 1;
               lead_fill = 0;
               write_group(seq, n);
            end else begin
               lead_buf[lead_fill] = b;
               lead_fill++;
            end
            return;
         end
         // broken sequence: replace the lead, rescan what followed it
         n = lead_fill;
         for (i = 0; i < n; i++) rescan[i] = lead_buf[i];
         lead_fill = 0;
         write_group({24'h0, utf8s_pkg::QMARK}, 1);
         for (i = 1; i < n; i++) scan_lead(rescan[i]);
      end
      if (b == utf8s_pkg::TERMINATOR) begin
         push_out(utf8s_pkg::TERMINATOR, 1'b1);
         lead_fill   = 0;
         seq_total   = 0;
         out_written = 0;
         out_halted  = 1'b0;
         return;
      end
      if (out_halted) return;
      scan_lead(b);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_out.delete();
         lead_fill      = 0;
         seq_total      = 0;
         out_written    = 0;
         out_halted     = 1'b0;
         marker_lf      = 1'b0;
         cap_limit      = utf8s_pkg::CAPACITY_RESET;
         mismatch_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[utf8s_pkg::CSR_SEL_BIT] == utf8s_pkg::CSR_CAPACITY)
               cap_limit = csr_pwdata[utf8s_pkg::CAP_W-1:0];
            else marker_lf = csr_pwdata[0];
         end
         if (req.valid && req.ready) sanitize_byte(req.data_byte);
         if (rsp.valid && rsp.ready) begin
            if (expected_out.size() == 0) begin
               report($sformatf("unexpected transaction byte %02h last %0b",
                                rsp.out_byte, rsp.is_last));
            end else begin
               want = expected_out.pop_front();
               if (rsp.out_byte !== want.value)
                  report($sformatf("out_byte %02h, expected %02h", rsp.out_byte, want.value));
               if (rsp.is_last !== want.last)
                  report($sformatf("is_last %0b, expected %0b on byte %02h",
                                   rsp.is_last, want.last, want.value));
            end
         end
      end
      pending_count = expected_out.size();
   end

endmodule

// ----- dv/utf8_sanitizer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_sanitizer_tb
// Drives directed and random zero-terminated byte strings into the sanitizer
// under both marker modes, several capacities and idle/stall patterns; the checker
// beside the block predicts and compares the output stream.
// ----------------------------------------------------------------------------
module utf8_sanitizer_tb;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 64;
   localparam int STAGE_ITEMS  = 40;
   localparam int STAGES       = 8;

   logic                             clock;
   logic                             reset;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [utf8s_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [utf8s_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [utf8s_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   int                    mismatch_count;
   int                    pending_count;
   int                    send_idle;
   int                    rcv_stall;
   int                    stall_cycles = 0;
   int                    items_sent;
   int                    stage_start;
   int                    cap_set [STAGES];

   logic [7:0] directed_seq [24] = '{
      8'hC0, 8'h41, 8'h7F, 8'h01, utf8s_pkg::MARKER,
      8'hC3, 8'hA9,
      8'hE2, 8'h82, 8'hAC,
      8'hF0, 8'h9F, 8'h98, 8'h80,
      8'h80, 8'hFF, 8'hF8,
      8'hE2, utf8s_pkg::MARKER, 8'h41,
      8'hF0, 8'h80, utf8s_pkg::MARKER, utf8s_pkg::TERMINATOR
   };

   utf8s_req_if req_if ();
   utf8s_rsp_if rsp_if ();

   utf8_sanitizer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   utf8_sanitizer_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rcv_stall);
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= IDLE_LIMIT) begin
         $display("utf8_sanitizer_tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= value;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // hold the sender until every result is out and the block has settled
   task automatic drain;
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // mostly well-formed text with some broken sequences and raw noise
   task automatic send_random_string;
      int n_units;
      int kind;
      int len;
      int keep;
      n_units = $urandom_range(12);
      repeat (n_units) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            send_byte(8'($urandom_range(8'h7F, 8'h01)));
         end else if (kind < 45) begin
            send_byte(utf8s_pkg::MARKER);
         end else if (kind < 85) begin
            len  = $urandom_range(4, 2);
            keep = (kind < 75) ? len - 1 : $urandom_range(len - 2, 0);
            case (len)
               2: begin
                  send_byte(8'($urandom_range(8'hDF, 8'hC0)));
               end
               3: begin
                  send_byte(8'($urandom_range(8'hEF, 8'hE0)));
               end
               default: begin
                  send_byte(8'($urandom_range(8'hF7, 8'hF0)));
               end
            endcase
            repeat (keep) send_byte(8'($urandom_range(8'hBF, 8'h80)));
         end else begin
            send_byte(8'($urandom_range(255)));
         end
      end
      send_byte(utf8s_pkg::TERMINATOR);
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      send_idle        = 0;
      rcv_stall        = 0;
      items_sent       = 0;
      cap_set          = '{1024, 2, 16, 8191, 4096, 0, 1, 5};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_seq[i]) send_byte(directed_seq[i]);

      for (int stage = 0; stage < STAGES; stage++) begin
         drain();
         // upper data bits are don't-care; randomize them
         write_reg(utf8s_pkg::CSR_LINEFEED, ($urandom & 32'hFFFF_FFFE) | 32'(stage[1]));
         write_reg(utf8s_pkg::CSR_CAPACITY, ($urandom & 32'hFFFF_E000) | 32'(cap_set[stage]));
         case (stage % 4)
            0: begin
               send_idle = 0;
               rcv_stall = 0;
            end
            1: begin
               send_idle = 84;
               rcv_stall = 0;
            end
            2: begin
               send_idle = 0;
               rcv_stall = 84;
            end
            default: begin
               send_idle = 12;
               rcv_stall = 12;
            end
         endcase
         stage_start = items_sent;
         while (items_sent - stage_start < STAGE_ITEMS) send_random_string();
      end

      drain();
      if (mismatch_count == 0) begin
         $display("utf8_sanitizer_tb OK");
      end else begin
         $display("utf8_sanitizer_tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/utf8s_pkg.sv
sv/utf8s_req_if.sv
sv/utf8s_rsp_if.sv
sv/utf8s_ctrl.sv
sv/utf8s_dpath.sv
sv/utf8_sanitizer.sv
dv/utf8_sanitizer_checker.sv
dv/utf8_sanitizer_tb.sv
